// ----- design/lck_pkg.sv -----
// Shared types, constants and modular-arithmetic step functions for the
// letter cipher unit. No dependencies.
`default_nettype none

package lck_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned MOD_W       = 5;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned MOD_STEPS   = BYTE_W;   // bits reduced per config register
   localparam int unsigned CNT_W       = $clog2(MOD_STEPS);

   localparam logic [MOD_W-1:0]  KEY_SEED    = MOD_W'(3);
   localparam logic [BYTE_W-1:0] LETTER_LO   = BYTE_W'(65);
   localparam logic [BYTE_W-1:0] LETTER_HI   = BYTE_W'(90);
   localparam logic [BYTE_W-1:0] MULT_RESET  = BYTE_W'(1);
   localparam logic [BYTE_W-1:0] INC_RESET   = BYTE_W'(1);
   localparam logic [MOD_W-1:0]  MOD_RESET   = MOD_W'(26);
   localparam logic [MOD_W-1:0]  GCD_UNITY   = MOD_W'(1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MULTIPLIER,
      CSR_INCREMENT,
      CSR_MODULUS,
      CSR_DIRECTION
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_GCD,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              start_of_message;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              rejected;
   } rsp_type;

   // One restoring-division step: shift in a bit, subtract m if it fits.
   // Requires rem < m.
   function automatic logic [MOD_W-1:0] mod_step(input logic [MOD_W-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [MOD_W-1:0] m);
      logic [MOD_W:0] t;
      t = {rem, bit_in};
      if (t >= {1'b0, m}) t = t - {1'b0, m};
      return t[MOD_W-1:0];
   endfunction

   // One step of an MSB-first modular multiply: 2*acc + (bit ? addend : 0), mod m.
   // acc, addend < m, so at most two subtractions.
   function automatic logic [MOD_W-1:0] mulmod_step(input logic [MOD_W-1:0] acc,
                                                    input logic bit_in,
                                                    input logic [MOD_W-1:0] addend,
                                                    input logic [MOD_W-1:0] m);
      logic [MOD_W+1:0] t;
      t = {1'b0, acc, 1'b0} + (bit_in ? {2'b00, addend} : '0);
      if (t >= {2'b00, m}) t = t - {2'b00, m};
      if (t >= {2'b00, m}) t = t - {2'b00, m};
      return t[MOD_W-1:0];
   endfunction

   function automatic logic [MOD_W-1:0] add_mod(input logic [MOD_W-1:0] a,
                                                input logic [MOD_W-1:0] b,
                                                input logic [MOD_W-1:0] m);
      logic [MOD_W:0] t;
      t = {1'b0, a} + {1'b0, b};
      if (t >= {1'b0, m}) t = t - {1'b0, m};
      return t[MOD_W-1:0];
   endfunction

   function automatic logic [MOD_W-1:0] sub_mod(input logic [MOD_W-1:0] a,
                                                input logic [MOD_W-1:0] b,
                                                input logic [MOD_W-1:0] m);
      logic [MOD_W:0] t;
      if (a >= b) t = {1'b0, a} - {1'b0, b};
      else        t = {1'b0, a} + {1'b0, m} - {1'b0, b};
      return t[MOD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/lck_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// Payload types come from lck_pkg at the point of instantiation.
`default_nettype none

interface lck_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/lcg_keystream_letter_cipher_unit.sv -----
// Letter cipher with an LCG keystream, bit-serial modular arithmetic.
// A letter's result comes after 5 serial key-bit steps and the finish step; other bytes and
// rejected items go straight to the finish step, which waits while the response is held. A new
// byte is taken only once the last one is through. A config write keeps the unit busy for the
// serial reduction and the gcd steps; a further write restarts that check.
// Reset (synchronous, active high): registers to defaults, key 3, coprime flag set; no sweep.
// Depends on lck_pkg and lck_stream_if.
`default_nettype none

module lcg_keystream_letter_cipher_unit (
   input  logic                             clock,
   input  logic                             reset,
   lck_stream_if.sink                       req_if,
   lck_stream_if.source                     rsp_if,
   input  logic                             csr_write_enable,
   input  logic [lck_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lck_pkg::BYTE_W-1:0]       csr_write_data
);
   import lck_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [BYTE_W-1:0] mult_ff, mult_in;
   logic [BYTE_W-1:0] inc_ff, inc_in;
   logic [MOD_W-1:0]  modulus_ff, modulus_in;
   logic              direction_ff, direction_in;
   logic              coprime_ff, coprime_in;
   logic [BYTE_W-1:0] mult_sr_ff, mult_sr_in;
   logic [BYTE_W-1:0] inc_sr_ff, inc_sr_in;
   logic [MOD_W-1:0]  mult_rem_ff, mult_rem_in;
   logic [MOD_W-1:0]  inc_rem_ff, inc_rem_in;
   logic [MOD_W-1:0]  gcd_a_ff, gcd_a_in;
   logic [MOD_W-1:0]  gcd_b_ff, gcd_b_in;

   logic [MOD_W-1:0]  key_ff, key_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              letter_ff, letter_in;
   logic [MOD_W-1:0]  let_sr_ff, let_sr_in;
   logic [MOD_W-1:0]  let_rem_ff, let_rem_in;
   logic [MOD_W-1:0]  key_rem_ff, key_rem_in;
   logic [MOD_W-1:0]  acc_ff, acc_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              is_letter;
   logic              out_free;
   logic [MOD_W-1:0]  shift_res;
   logic [BYTE_W-1:0] letter_off;
   logic [MOD_W-1:0]  mult_rem_next;

   assign is_letter  = (req_if.payload.in_byte >= LETTER_LO) &&
                       (req_if.payload.in_byte <= LETTER_HI);
   assign letter_off = req_if.payload.in_byte - LETTER_LO;
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign shift_res  = direction_ff ? sub_mod(let_rem_ff, key_rem_ff, modulus_ff)
                                    : add_mod(let_rem_ff, key_rem_ff, modulus_ff);
   assign mult_rem_next = mod_step(mult_rem_ff, mult_sr_ff[BYTE_W-1], modulus_ff);

   assign req_if.ready   = (state_ff == ST_IDLE) && !csr_write_enable;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mult_in      = mult_ff;
      inc_in       = inc_ff;
      modulus_in   = modulus_ff;
      direction_in = direction_ff;
      coprime_in   = coprime_ff;
      mult_sr_in   = mult_sr_ff;
      inc_sr_in    = inc_sr_ff;
      mult_rem_in  = mult_rem_ff;
      inc_rem_in   = inc_rem_ff;
      gcd_a_in     = gcd_a_ff;
      gcd_b_in     = gcd_b_ff;
      key_in       = key_ff;
      byte_in      = byte_ff;
      letter_in    = letter_ff;
      let_sr_in    = let_sr_ff;
      let_rem_in   = let_rem_ff;
      key_rem_in   = key_rem_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid && req_if.ready) begin
               byte_in    = req_if.payload.in_byte;
               key_in     = req_if.payload.start_of_message ? KEY_SEED : key_ff;
               letter_in  = coprime_ff && is_letter;
               let_sr_in  = letter_off[MOD_W-1:0];
               let_rem_in = '0;
               key_rem_in = '0;
               acc_in     = '0;
               cnt_in     = '0;
               state_in   = (coprime_ff && is_letter) ? ST_RUN : ST_FINISH;
            end
         end

         ST_MOD: begin
            // working copies shift out MSB first
            mult_sr_in  = {mult_sr_ff[BYTE_W-2:0], 1'b0};
            inc_sr_in   = {inc_sr_ff[BYTE_W-2:0], 1'b0};
            mult_rem_in = mult_rem_next;
            inc_rem_in  = mod_step(inc_rem_ff, inc_sr_ff[BYTE_W-1], modulus_ff);
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MOD_STEPS - 1)) begin
               if (modulus_ff == '0) begin
                  coprime_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  // gcd(mult, m) = gcd(m, mult mod m)
                  gcd_a_in = modulus_ff;
                  gcd_b_in = mult_rem_next;
                  state_in = ST_GCD;
               end
            end
         end

         ST_GCD: begin
            if (gcd_b_ff == '0) begin
               coprime_in = (gcd_a_ff == GCD_UNITY);
               state_in   = ST_IDLE;
            end else if (gcd_a_ff >= gcd_b_ff) begin
               gcd_a_in = gcd_a_ff - gcd_b_ff;
            end else begin
               gcd_a_in = gcd_b_ff;
               gcd_b_in = gcd_a_ff;
            end
         end

         ST_RUN: begin
            // key bits MSB first: key mod m and (mult mod m) * key mod m in step
            key_in     = {key_ff[MOD_W-2:0], key_ff[MOD_W-1]};
            key_rem_in = mod_step(key_rem_ff, key_ff[MOD_W-1], modulus_ff);
            acc_in     = mulmod_step(acc_ff, key_ff[MOD_W-1], mult_rem_ff, modulus_ff);
            let_sr_in  = {let_sr_ff[MOD_W-2:0], 1'b0};
            let_rem_in = mod_step(let_rem_ff, let_sr_ff[MOD_W-1], modulus_ff);
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MOD_W - 1)) state_in = ST_FINISH;
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.rejected = !coprime_ff;
               if (!coprime_ff)    rsp_data_in.out_byte = '0;
               else if (letter_ff) rsp_data_in.out_byte = LETTER_LO + BYTE_W'(shift_res);
               else                rsp_data_in.out_byte = byte_ff;
               if (letter_ff) key_in = add_mod(acc_ff, inc_rem_ff, modulus_ff);
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // a register write restarts the reduction and gcd check from the top
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MULTIPLIER: mult_in      = csr_write_data;
            CSR_INCREMENT:  inc_in       = csr_write_data;
            CSR_MODULUS:    modulus_in   = csr_write_data[MOD_W-1:0];
            CSR_DIRECTION:  direction_in = csr_write_data[0];
         endcase
         mult_sr_in  = mult_in;
         inc_sr_in   = inc_in;
         mult_rem_in = '0;
         inc_rem_in  = '0;
         cnt_in      = '0;
         state_in    = ST_MOD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         mult_ff      <= MULT_RESET;
         inc_ff       <= INC_RESET;
         modulus_ff   <= MOD_RESET;
         direction_ff <= 1'b0;
         coprime_ff   <= 1'b1;
         mult_rem_ff  <= MULT_RESET[MOD_W-1:0];
         inc_rem_ff   <= INC_RESET[MOD_W-1:0];
         key_ff       <= KEY_SEED;
         letter_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mult_ff      <= mult_in;
         inc_ff       <= inc_in;
         modulus_ff   <= modulus_in;
         direction_ff <= direction_in;
         coprime_ff   <= coprime_in;
         mult_rem_ff  <= mult_rem_in;
         inc_rem_ff   <= inc_rem_in;
         key_ff       <= key_in;
         letter_ff    <= letter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mult_sr_ff  <= mult_sr_in;
      inc_sr_ff   <= inc_sr_in;
      gcd_a_ff    <= gcd_a_in;
      gcd_b_ff    <= gcd_b_in;
      byte_ff     <= byte_in;
      let_sr_ff   <= let_sr_in;
      let_rem_ff  <= let_rem_in;
      key_rem_ff  <= key_rem_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.rejected |-> rsp_data_ff.out_byte == '0)
      else $error("rejected transaction carries a non-zero byte");

   a_run_reduced: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> (acc_ff < modulus_ff) && (key_rem_ff < modulus_ff) &&
                             (let_rem_ff < modulus_ff))
      else $error("serial remainder not reduced below modulus");

   a_key_reduced: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && letter_ff && out_free |=> key_ff < modulus_ff)
      else $error("advanced key not reduced below modulus");

   a_csr_recheck: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && csr_write_enable |=> state_ff == ST_MOD && !req_if.ready)
      else $error("config write did not start the coprime check");

endmodule

`default_nettype wire
